### rtl/core/pma_pkg.sv
// Package with shared types, codes and the divide-by-255 helper of the pixel mask block.
`default_nettype none
package pma_pkg;

	localparam int unsigned PIX_W = 8;
	localparam int unsigned PROD_W = 2 * PIX_W;
	localparam int unsigned MODE_W = 2;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 2;
	localparam int unsigned NUM_LANES = 3;

	localparam logic [PIX_W-1:0] FULL_SCALE = 8'hff;
	localparam logic [PIX_W-1:0] CHROMA_MID = 8'h80;

	// Pixel mode codes; the unused code behaves as alpha replacement.
	localparam logic [MODE_W-1:0] MODE_RGB = 2'd0;
	localparam logic [MODE_W-1:0] MODE_YUV = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ALPHA = 2'd2;
	localparam logic [MODE_W-1:0] MODE_ALPHA_ALIAS = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT = 1'b1;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [PROD_W-1:0] prod_t;

	// Stage enables handed from the pipeline control to the lanes and the merge stage.
	typedef struct packed {
		logic adv_s1;
		logic adv_s2;
	} ctl_t;

	// Exact floor(p / 255) for every product of two bytes.
	function automatic pix_t div255(input prod_t p);
		logic [PROD_W:0] t;
		t = {1'b0, p} + {{(PROD_W + 1 - PIX_W){1'b0}}, p[PROD_W-1:PIX_W]} + 1'b1;
		return t[PROD_W-1:PIX_W];
	endfunction

endpackage
`default_nettype wire

### rtl/core/pma_pix_in_if.sv
// Input channel carrying one pixel word with its mask byte.
`default_nettype none
interface pma_pix_in_if
	import pma_pkg::*;
	();
	logic valid;
	logic ready;
	pix_t mask_value;
	pix_t comp0;
	pix_t comp1;
	pix_t comp2;
	logic frame_end;

	modport source (output valid, mask_value, comp0, comp1, comp2, frame_end, input ready);
	modport sink (input valid, mask_value, comp0, comp1, comp2, frame_end, output ready);
endinterface
`default_nettype wire

### rtl/core/pma_pix_out_if.sv
// Output channel carrying one masked pixel word.
`default_nettype none
interface pma_pix_out_if
	import pma_pkg::*;
	();
	logic valid;
	logic ready;
	pix_t out0;
	pix_t out1;
	pix_t out2;
	pix_t alpha_out;
	logic last_pixel;

	modport source (output valid, out0, out1, out2, alpha_out, last_pixel, input ready);
	modport sink (input valid, out0, out1, out2, alpha_out, last_pixel, output ready);
endinterface
`default_nettype wire

### rtl/core/pma_cfg_if.sv
// Configuration write channel with register index and write data.
`default_nettype none
interface pma_cfg_if
	import pma_pkg::*;
	();
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/core/pma_lane.sv
// One component lane: registered coverage product, then divide by 255 and chroma recentering.
`default_nettype none
module pma_lane
	import pma_pkg::*;
(
	input  wire logic clk,
	input  wire ctl_t ctl,
	input  wire pix_t coverage,
	input  wire pix_t comp,
	input  wire logic chroma,
	output pix_t      result
);

	pix_t  operand;
	logic  neg;
	prod_t prod_s1;
	logic  neg_s1;
	logic  chroma_s1;
	pix_t  quot;

	// Chroma is scaled by its distance from mid-scale; the sign is put back afterwards,
	// which gives truncation toward zero.
	always_comb begin
		neg = chroma && (comp < CHROMA_MID);
		if (!chroma) begin
			operand = comp;
		end else if (neg) begin
			operand = CHROMA_MID - comp;
		end else begin
			operand = comp - CHROMA_MID;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv_s1) begin
			prod_s1 <= coverage * operand;
			neg_s1 <= neg;
			chroma_s1 <= chroma;
		end
	end

	assign quot = div255(prod_s1);

	always_comb begin
		if (!chroma_s1) begin
			result = quot;
		end else if (neg_s1) begin
			result = CHROMA_MID - quot;
		end else begin
			result = CHROMA_MID + quot;
		end
	end

endmodule
`default_nettype wire

### rtl/core/pma_merge.sv
// Merge stage: combines the lane results with pass-through data into the output register.
`default_nettype none
module pma_merge
	import pma_pkg::*;
(
	input  wire logic clk,
	input  wire ctl_t ctl,
	input  wire pix_t lane_res [NUM_LANES],
	input  wire pix_t comp_s1 [NUM_LANES],
	input  wire logic pass_s1,
	input  wire pix_t alpha_s1,
	input  wire logic last_s1,
	output pix_t      res_s2 [NUM_LANES],
	output pix_t      alpha_s2,
	output logic      last_s2
);

	always_ff @(posedge clk) begin
		if (ctl.adv_s2) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				res_s2[i] <= pass_s1 ? comp_s1[i] : lane_res[i];
			end
			alpha_s2 <= alpha_s1;
			last_s2 <= last_s1;
		end
	end

endmodule
`default_nettype wire

### rtl/core/pixel_mask_apply.sv
// Top level of the pixel mask block: configuration, pipeline control, lanes and merge.
//
// The block applies an 8-bit coverage mask to a three-component pixel. Coverage is
// 255 minus the mask byte, or the mask byte itself when invert is set. In RGB mode
// each component is scaled by coverage/255 with truncation; in YUV mode luma is
// scaled the same way and each chroma is scaled around 128 with truncation toward
// zero; in alpha mode (and the unused mode code) the components pass unchanged.
// The coverage always appears on alpha_out and the frame-end flag travels with its
// pixel. One pixel word is accepted every clock cycle unless the first stage is full
// and the output stalls. Each word passes through the register stages in order: the
// first holds the coverage product of each of the three component lanes, the second
// is the output register of the merge stage. Each stage advances on its own, so a
// bubble in the pipe is filled while a finished word waits on the output. Configuration
// writes are always taken and must only be made while no pixel is in flight.
`default_nettype none
module pixel_mask_apply
	import pma_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	pma_pix_in_if.sink    pix_in,
	pma_pix_out_if.source pix_out,
	pma_cfg_if.sink       cfg
);

	logic [MODE_W-1:0] pixel_mode_q;
	logic              invert_q;

	ctl_t ctl;
	logic in_fire;
	logic valid_s1;
	logic valid_s2;

	pix_t coverage;
	logic yuv_mode;
	pix_t comp_in [NUM_LANES];
	pix_t comp_s1 [NUM_LANES];
	pix_t lane_res [NUM_LANES];
	pix_t res_s2 [NUM_LANES];
	logic pass_s1;
	pix_t alpha_s1;
	logic last_s1;
	pix_t alpha_s2;
	logic last_s2;

	// Configuration registers. Writes are accepted in every cycle.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_mode_q <= MODE_RGB;
			invert_q <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_PIXEL_MODE: pixel_mode_q <= cfg.data[MODE_W-1:0];
				REG_INVERT:     invert_q <= cfg.data[0];
			endcase
		end
	end

	// Pipeline control. The output stage moves when it is empty or its word is taken;
	// the first stage moves when it is empty or the output stage is moving.
	assign ctl.adv_s2 = !valid_s2 || pix_out.ready;
	assign ctl.adv_s1 = !valid_s1 || ctl.adv_s2;
	assign pix_in.ready = ctl.adv_s1;
	assign in_fire = pix_in.valid && pix_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ctl.adv_s1) begin
				valid_s1 <= in_fire;
			end
			if (ctl.adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Coverage: the mask byte itself, or its complement against full scale.
	assign coverage = invert_q ? pix_in.mask_value : FULL_SCALE - pix_in.mask_value;
	assign yuv_mode = (pixel_mode_q == MODE_YUV);

	assign comp_in[0] = pix_in.comp0;
	assign comp_in[1] = pix_in.comp1;
	assign comp_in[2] = pix_in.comp2;

	// Lane 0 carries red or luma and is never treated as chroma.
	generate
		for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
			pma_lane u_lane (
				.clk      (clk),
				.ctl      (ctl),
				.coverage (coverage),
				.comp     (comp_in[g]),
				.chroma   ((g != 0) && yuv_mode),
				.result   (lane_res[g])
			);
		end
	endgenerate

	// Side data that rides alongside the lane products.
	always_ff @(posedge clk) begin
		if (ctl.adv_s1) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				comp_s1[i] <= comp_in[i];
			end
			pass_s1 <= (pixel_mode_q == MODE_ALPHA) || (pixel_mode_q == MODE_ALPHA_ALIAS);
			alpha_s1 <= coverage;
			last_s1 <= pix_in.frame_end;
		end
	end

	pma_merge u_merge (
		.clk      (clk),
		.ctl      (ctl),
		.lane_res (lane_res),
		.comp_s1  (comp_s1),
		.pass_s1  (pass_s1),
		.alpha_s1 (alpha_s1),
		.last_s1  (last_s1),
		.res_s2   (res_s2),
		.alpha_s2 (alpha_s2),
		.last_s2  (last_s2)
	);

	assign pix_out.valid = valid_s2;
	assign pix_out.out0 = res_s2[0];
	assign pix_out.out1 = res_s2[1];
	assign pix_out.out2 = res_s2[2];
	assign pix_out.alpha_out = alpha_s2;
	assign pix_out.last_pixel = last_s2;

	// An accepted word always lands in the first stage.
	a_fire_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> valid_s1)
		else $error("accepted pixel word did not reach the first stage");

	// A word in the first stage moves to the output stage whenever that stage advances.
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && ctl.adv_s2) |=> valid_s2)
		else $error("pixel word lost between the first and output stages");

	// An empty first stage never holds off the input.
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> pix_in.ready)
		else $error("input stalled while the first stage was empty");

	// A full first stage behind a stalled output word stays put.
	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !pix_out.ready) |=> (valid_s1 && $stable(alpha_s1)))
		else $error("first stage changed while the pipe was stalled");

endmodule
`default_nettype wire
